FILE: hdl/assert_macros.svh
// Assertion macros shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// The condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: hdl/gtt_pkg.sv
// Types, character codes and helper functions shared by the tokenizer.
`timescale 1ns / 1ps

package gtt_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam logic [7:0] CH_DIGIT9 = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UPPERA = 8'h41;
    localparam logic [7:0] CH_UPPERZ = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOWERA = 8'h61;
    localparam logic [7:0] CH_LOWERZ = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_IDENT,
        MODE_STRING,
        MODE_DASH,
        MODE_DEAD
    } scan_mode_t;

    typedef enum logic [3:0] {
        KIND_EOF,
        KIND_IDENT,
        KIND_STRING,
        KIND_INVALID,
        KIND_ARROW,
        KIND_PERIOD,
        KIND_COLON,
        KIND_SEMI,
        KIND_LBRACE,
        KIND_RBRACE,
        KIND_LPAREN,
        KIND_RPAREN
    } token_kind_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] offset;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
        logic        last;
    } token_t;

    // Up to two tokens produced by one byte; the second is only valid with the first.
    typedef struct packed {
        logic   valid0;
        logic   valid1;
        token_t tok0;
        token_t tok1;
    } tok_pair_t;

    function automatic logic is_space(input logic [7:0] b);
        return b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    endfunction

    function automatic logic is_ident_start(input logic [7:0] b);
        return b inside {[CH_UPPERA:CH_UPPERZ], [CH_LOWERA:CH_LOWERZ], CH_UNDER};
    endfunction

    function automatic logic is_ident_char(input logic [7:0] b);
        return is_ident_start(b) || (b inside {[CH_DIGIT0:CH_DIGIT9]});
    endfunction

    // Returns KIND_EOF when the byte is not a single punctuation mark.
    function automatic token_kind_t punct_kind(input logic [7:0] b);
        token_kind_t k;
        case (b)
            CH_PERIOD: k = KIND_PERIOD;
            CH_COLON:  k = KIND_COLON;
            CH_SEMI:   k = KIND_SEMI;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            default:   k = KIND_EOF;
        endcase
        return k;
    endfunction

endpackage

FILE: hdl/gtt_byte_if.sv
// Handshake channel that carries one source byte per item.
`timescale 1ns / 1ps

interface gtt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

FILE: hdl/gtt_token_if.sv
// Handshake channel that carries one token per item.
`timescale 1ns / 1ps

interface gtt_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] token_offset;
    logic [15:0] token_length;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        last_of_run;

    modport source (
        output valid, output token_kind, output token_offset, output token_length,
        output start_line, output start_column, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input token_offset, input token_length,
        input start_line, input start_column, input last_of_run, output ready
    );
endinterface

FILE: hdl/grammar_text_tokenizer.sv
// An accepted byte is scanned from the input register; its tokens enter the token queue.
// Throughput: one byte per cycle while ready is high; one token leaves per cycle on pop.
// A byte that closes an identifier and forms a token of its own pushes two tokens.
// Ready drops only when the eight-entry token queue lacks room for the worst case.
// Reset is asynchronous, active low: scanner idle, position 0, line and column 1.
// The queue empties at reset; no clearing pass follows.
`timescale 1ns / 1ps

module grammar_text_tokenizer #(
    parameter int POSITION_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    gtt_byte_if.sink        byte_in,
    gtt_token_if.source     token_out
);

    localparam int CNT_W = gtt_pkg::FIFO_CNT_W;

    // Input register: the accepted byte is held here and scanned in the cycle after it is accepted.
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_accept;

    gtt_pkg::tok_pair_t     push;
    gtt_pkg::token_t        head;
    logic [CNT_W-1:0]       count;
    logic [CNT_W:0]         worst_fill;
    logic                   out_pop;

    // The byte in the input register and the new byte may each push two tokens.
    always_comb
    begin
        worst_fill = {1'b0, count} + (in_valid_reg ? (CNT_W + 1)'(4) : (CNT_W + 1)'(2));
    end

    assign byte_in.ready = worst_fill <= (CNT_W + 1)'(gtt_pkg::FIFO_DEPTH);
    assign in_accept     = byte_in.valid && byte_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= byte_in.text_byte;
        end
    end

    gtt_scan_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scan_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_valid_reg),
        .text_byte  (in_byte_reg),
        .push       (push)
    );

    gtt_token_fifo u_token_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (out_pop),
        .head  (head),
        .count (count)
    );

    // The head of the queue is the output register of the token channel.
    assign token_out.valid        = count != '0;
    assign out_pop                = token_out.valid && token_out.ready;
    assign token_out.token_kind   = head.kind;
    assign token_out.token_offset = head.offset;
    assign token_out.token_length = head.length;
    assign token_out.start_line   = head.line;
    assign token_out.start_column = head.column;
    assign token_out.last_of_run  = head.last;

endmodule

FILE: hdl/gtt_scan_core.sv
// Lexer state machine: scans one byte per cycle and produces up to two tokens.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gtt_scan_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic [7:0]          text_byte,
    output gtt_pkg::tok_pair_t  push
);

    localparam logic [POSITION_BITS-1:0] COUNT_ONE = POSITION_BITS'(1);
    localparam logic [POSITION_BITS-1:0] LEN_ARROW = POSITION_BITS'(2);

    gtt_pkg::scan_mode_t        mode_reg, mode_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;
    logic [POSITION_BITS-1:0]   line_reg, line_next;
    logic [POSITION_BITS-1:0]   col_reg, col_next;
    logic [POSITION_BITS-1:0]   spos_reg, spos_next;
    logic [POSITION_BITS-1:0]   sline_reg, sline_next;
    logic [POSITION_BITS-1:0]   scol_reg, scol_next;

    logic [POSITION_BITS-1:0]   cons_pos, cons_line, cons_col;

    gtt_pkg::scan_mode_t        idle_mode;
    logic [POSITION_BITS-1:0]   idle_pos, idle_line, idle_col;
    logic [POSITION_BITS-1:0]   idle_spos, idle_sline, idle_scol;
    logic                       idle_emit;
    gtt_pkg::token_t            idle_tok;
    gtt_pkg::token_kind_t       idle_punct;

    logic                       lead_valid;
    gtt_pkg::token_t            lead_tok;
    gtt_pkg::token_t            fail_tok;
    logic                       use_idle;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (&v) ? v : v + COUNT_ONE;
    endfunction

    function automatic gtt_pkg::token_t make_token(
        input gtt_pkg::token_kind_t     kind,
        input logic [POSITION_BITS-1:0] off,
        input logic [POSITION_BITS-1:0] len,
        input logic [POSITION_BITS-1:0] line,
        input logic [POSITION_BITS-1:0] col
    );
        gtt_pkg::token_t t;
        t.kind   = kind;
        t.offset = 16'(off);
        t.length = 16'(len);
        t.line   = 16'(line);
        t.column = 16'(col);
        t.last   = 1'b0;
        return t;
    endfunction

    // Counters after the current byte is consumed; a line feed starts a new line.
    always_comb
    begin
        cons_pos = sat_inc(pos_reg);
        if (text_byte == gtt_pkg::CH_LF)
        begin
            cons_line = sat_inc(line_reg);
            cons_col  = COUNT_ONE;
        end
        else
        begin
            cons_line = line_reg;
            cons_col  = sat_inc(col_reg);
        end
    end

    // Handling of a byte seen between tokens.
    always_comb
    begin
        idle_punct = gtt_pkg::punct_kind(text_byte);
        idle_mode  = gtt_pkg::MODE_IDLE;
        idle_pos   = pos_reg;
        idle_line  = line_reg;
        idle_col   = col_reg;
        idle_spos  = spos_reg;
        idle_sline = sline_reg;
        idle_scol  = scol_reg;
        idle_emit  = 1'b0;
        idle_tok   = make_token(gtt_pkg::KIND_EOF, pos_reg, '0, line_reg, col_reg);

        if (text_byte == gtt_pkg::CH_END)
        begin
            idle_emit = 1'b1;
            idle_pos  = '0;
            idle_line = COUNT_ONE;
            idle_col  = COUNT_ONE;
        end
        else if (gtt_pkg::is_space(text_byte))
        begin
            idle_pos  = cons_pos;
            idle_line = cons_line;
            idle_col  = cons_col;
        end
        else if (text_byte == gtt_pkg::CH_SLASH || text_byte == gtt_pkg::CH_DASH ||
                 gtt_pkg::is_ident_start(text_byte))
        begin
            idle_spos  = pos_reg;
            idle_sline = line_reg;
            idle_scol  = col_reg;
            idle_pos   = cons_pos;
            idle_line  = cons_line;
            idle_col   = cons_col;
            if (text_byte == gtt_pkg::CH_SLASH)
            begin
                idle_mode = gtt_pkg::MODE_SLASH;
            end
            else if (text_byte == gtt_pkg::CH_DASH)
            begin
                idle_mode = gtt_pkg::MODE_DASH;
            end
            else
            begin
                idle_mode = gtt_pkg::MODE_IDENT;
            end
        end
        else if (text_byte == gtt_pkg::CH_QUOTE)
        begin
            // The string text starts after the opening quote.
            idle_spos  = cons_pos;
            idle_sline = line_reg;
            idle_scol  = col_reg;
            idle_pos   = cons_pos;
            idle_line  = cons_line;
            idle_col   = cons_col;
            idle_mode  = gtt_pkg::MODE_STRING;
        end
        else if (idle_punct != gtt_pkg::KIND_EOF)
        begin
            idle_emit = 1'b1;
            idle_tok  = make_token(idle_punct, pos_reg, COUNT_ONE, line_reg, col_reg);
            idle_pos  = cons_pos;
            idle_line = cons_line;
            idle_col  = cons_col;
        end
        else
        begin
            idle_emit = 1'b1;
            idle_tok  = make_token(gtt_pkg::KIND_INVALID, pos_reg, '0, line_reg, col_reg);
            idle_mode = gtt_pkg::MODE_DEAD;
        end
    end

    // Main next-state logic by scan mode.
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        spos_next  = spos_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        lead_valid = 1'b0;
        use_idle   = 1'b0;
        fail_tok   = make_token(gtt_pkg::KIND_INVALID, spos_reg, '0, sline_reg, scol_reg);
        lead_tok   = fail_tok;
        push       = '0;

        if (byte_valid)
        begin
            case (mode_reg)
                gtt_pkg::MODE_SLASH:
                begin
                    if (text_byte == gtt_pkg::CH_SLASH)
                    begin
                        mode_next = gtt_pkg::MODE_COMMENT;
                        pos_next  = cons_pos;
                        line_next = cons_line;
                        col_next  = cons_col;
                    end
                    else
                    begin
                        lead_valid = 1'b1;
                    end
                end
                gtt_pkg::MODE_DASH:
                begin
                    if (text_byte == gtt_pkg::CH_GT)
                    begin
                        lead_valid = 1'b1;
                        lead_tok   = make_token(gtt_pkg::KIND_ARROW, spos_reg, LEN_ARROW,
                                                sline_reg, scol_reg);
                        mode_next  = gtt_pkg::MODE_IDLE;
                        pos_next   = cons_pos;
                        line_next  = cons_line;
                        col_next   = cons_col;
                    end
                    else
                    begin
                        lead_valid = 1'b1;
                    end
                end
                gtt_pkg::MODE_COMMENT:
                begin
                    if (text_byte == gtt_pkg::CH_END || text_byte == gtt_pkg::CH_LF)
                    begin
                        use_idle = 1'b1;
                    end
                    else
                    begin
                        pos_next  = cons_pos;
                        line_next = cons_line;
                        col_next  = cons_col;
                    end
                end
                gtt_pkg::MODE_IDENT:
                begin
                    if (gtt_pkg::is_ident_char(text_byte))
                    begin
                        pos_next  = cons_pos;
                        line_next = cons_line;
                        col_next  = cons_col;
                    end
                    else
                    begin
                        lead_valid = 1'b1;
                        lead_tok   = make_token(gtt_pkg::KIND_IDENT, spos_reg,
                                                pos_reg - spos_reg, sline_reg, scol_reg);
                        use_idle   = 1'b1;
                    end
                end
                gtt_pkg::MODE_STRING:
                begin
                    if (text_byte == gtt_pkg::CH_QUOTE)
                    begin
                        lead_valid = 1'b1;
                        lead_tok   = make_token(gtt_pkg::KIND_STRING, spos_reg,
                                                pos_reg - spos_reg, sline_reg, scol_reg);
                        mode_next  = gtt_pkg::MODE_IDLE;
                        pos_next   = cons_pos;
                        line_next  = cons_line;
                        col_next   = cons_col;
                    end
                    else if (text_byte == gtt_pkg::CH_END || text_byte == gtt_pkg::CH_CR ||
                             text_byte == gtt_pkg::CH_LF)
                    begin
                        lead_valid = 1'b1;
                    end
                    else
                    begin
                        pos_next  = cons_pos;
                        line_next = cons_line;
                        col_next  = cons_col;
                    end
                end
                gtt_pkg::MODE_DEAD:
                begin
                    if (text_byte == gtt_pkg::CH_END)
                    begin
                        mode_next = gtt_pkg::MODE_IDLE;
                        pos_next  = '0;
                        line_next = COUNT_ONE;
                        col_next  = COUNT_ONE;
                    end
                end
                default:
                begin
                    use_idle = 1'b1;
                end
            endcase

            // A failed token reports at its recorded start, then waits for the end byte.
            if (lead_valid && lead_tok.kind == gtt_pkg::KIND_INVALID)
            begin
                if (text_byte == gtt_pkg::CH_END)
                begin
                    mode_next = gtt_pkg::MODE_IDLE;
                    pos_next  = '0;
                    line_next = COUNT_ONE;
                    col_next  = COUNT_ONE;
                end
                else
                begin
                    mode_next = gtt_pkg::MODE_DEAD;
                end
            end

            if (use_idle)
            begin
                mode_next  = idle_mode;
                pos_next   = idle_pos;
                line_next  = idle_line;
                col_next   = idle_col;
                spos_next  = idle_spos;
                sline_next = idle_sline;
                scol_next  = idle_scol;
            end

            if (lead_valid)
            begin
                push.valid0 = 1'b1;
                push.tok0   = lead_tok;
                push.valid1 = use_idle && idle_emit;
                push.tok1   = idle_tok;
            end
            else if (use_idle && idle_emit)
            begin
                push.valid0 = 1'b1;
                push.tok0   = idle_tok;
            end
            push.tok0.last = !push.valid1;
            push.tok1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= gtt_pkg::MODE_IDLE;
            pos_reg   <= '0;
            line_reg  <= COUNT_ONE;
            col_reg   <= COUNT_ONE;
            spos_reg  <= '0;
            sline_reg <= COUNT_ONE;
            scol_reg  <= COUNT_ONE;
        end
        else
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            spos_reg  <= spos_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
        end
    end

    `ASSERT_IMPLY(a_pair_ordered, clk, rst_n, push.valid1, push.valid0)
    `ASSERT_IMPLY(a_pair_only_after_ident, clk, rst_n, push.valid1,
                  mode_reg == gtt_pkg::MODE_IDENT)
    `ASSERT_NEVER(a_counters_nonzero, clk, rst_n, line_reg == '0 || col_reg == '0)

endmodule

FILE: hdl/gtt_token_fifo.sv
// Small token queue that accepts up to two tokens and releases one per cycle on pop.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gtt_token_fifo (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gtt_pkg::tok_pair_t                 push,
    input  logic                               pop,
    output gtt_pkg::token_t                    head,
    output logic [gtt_pkg::FIFO_CNT_W-1:0]     count
);

    localparam int PTR_W = gtt_pkg::FIFO_PTR_W;
    localparam int CNT_W = gtt_pkg::FIFO_CNT_W;

    gtt_pkg::token_t    entry_reg [gtt_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [1:0]         push_n;
    logic [CNT_W:0]     fill_after;

    always_comb
    begin
        push_n     = {1'b0, push.valid0} + {1'b0, push.valid1};
        wr_next    = wr_reg + PTR_W'(push_n);
        rd_next    = rd_reg + PTR_W'(pop);
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);
        fill_after = {1'b0, count_reg} + (CNT_W + 1)'(push_n);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            entry_reg[wr_reg] <= push.tok0;
        end
        if (push.valid1)
        begin
            entry_reg[wr_reg + PTR_W'(1)] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    assign head  = entry_reg[rd_reg];
    assign count = count_reg;

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, fill_after > (CNT_W + 1)'(gtt_pkg::FIFO_DEPTH))
    `ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, count_reg != '0)
    `ASSERT_NEXT(a_pair_counted, clk, rst_n, push.valid1 && !pop,
                 count_reg == CNT_W'($past(count_reg) + CNT_W'(2)))

endmodule
